>>> hw/rtl/bpc_pkg.sv
// Shared types, register indexes and constants for the pressure compensation core.
// No dependencies.
package bpc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int DivBits  = 32;
    localparam int DivSideW = 84;

    typedef enum logic [CfgIdxW-1:0] {
        REG_OSS    = 3'd0,
        REG_AC1AC2 = 3'd1,
        REG_AC3AC4 = 3'd2,
        REG_AC5AC6 = 3'd3,
        REG_B1B2   = 3'd4,
        REG_MCMD   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] raw_temperature;
        logic        [18:0] raw_pressure;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] temperature_out;
        logic        [31:0] pressure_out;
        logic               divide_fault;
    } out_word_t;

    // one restoring division step: shift in a dividend bit, trial subtract
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
    } div_st_t;

    function automatic div_st_t div_step(div_st_t s, logic [31:0] d, logic [31:0] dvd_bits,
                                         logic [4:0] k);
        logic [32:0] r;
        logic [32:0] t;
        div_st_t     o;
        r = {s.rem, dvd_bits[k]};
        t = r - {1'b0, d};
        o.quo = {s.quo[30:0], ~t[32]};
        o.rem = t[32] ? r[31:0] : t[31:0];
        return o;
    endfunction

endpackage

>>> hw/rtl/bpc_stream_if.sv
// Valid/ready stream channel carrying one word of type T.
// No dependencies.
interface bpc_stream_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bpc_div_pipe.sv
// Pipelined unsigned 32-bit divider, four quotient bits per stage, with side payload.
// Depends on bpc_pkg.
module bpc_div_pipe
    import bpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [31:0]         dividend,
    input  logic [31:0]         divisor,
    input  logic [DivSideW-1:0] side_in,
    output logic                out_valid,
    output logic [31:0]         quotient,
    output logic [DivSideW-1:0] side_out
);
    localparam int Bps    = 4;
    localparam int Stages = DivBits / Bps;

    logic                v_reg    [Stages];
    div_st_t             st_reg   [Stages];
    logic [31:0]         dvd_reg  [Stages];
    logic [31:0]         dsr_reg  [Stages];
    logic [DivSideW-1:0] side_reg [Stages];
    div_st_t             st_next  [Stages];

    always_comb
    begin
        div_st_t s;
        s.rem = '0;
        s.quo = '0;
        for (int j = 0; j < Bps; j++)
            s = div_step(s, divisor, dividend, 5'(31 - j));
        st_next[0] = s;
        for (int i = 1; i < Stages; i++)
        begin
            s = st_reg[i-1];
            for (int j = 0; j < Bps; j++)
                s = div_step(s, dsr_reg[i-1], dvd_reg[i-1], 5'(31 - i*Bps - j));
            st_next[i] = s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Stages; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < Stages; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0]   <= st_next[0];
            dvd_reg[0]  <= dividend;
            dsr_reg[0]  <= divisor;
            side_reg[0] <= side_in;
            for (int i = 1; i < Stages; i++)
            begin
                st_reg[i]   <= st_next[i];
                dvd_reg[i]  <= dvd_reg[i-1];
                dsr_reg[i]  <= dsr_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[Stages-1];
    assign quotient  = st_reg[Stages-1].quo;
    assign side_out  = side_reg[Stages-1];
endmodule

>>> hw/rtl/barometric_pressure_compensation_core.sv
// Pressure compensation pipeline: temperature path, B3/B4/B7 path, final correction.
// Depends on bpc_pkg, bpc_stream_if and bpc_div_pipe.
// Throughput one word per cycle while the output is not stalled.
// Two 8-stage dividers set the depth; a stall freezes every stage together.
// Reset clears valid bits and all configuration registers to zero.
module barometric_pressure_compensation_core
    import bpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    bpc_stream_if.sink          in_ch,
    bpc_stream_if.source        out_ch
);
    logic [1:0]  oss_reg;
    logic [31:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg <= '0;
            c1_reg  <= '0;
            c2_reg  <= '0;
            c3_reg  <= '0;
            c4_reg  <= '0;
            c5_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_OSS:    oss_reg <= cfg_data[1:0];
                REG_AC1AC2: c1_reg  <= cfg_data;
                REG_AC3AC4: c2_reg  <= cfg_data;
                REG_AC5AC6: c3_reg  <= cfg_data;
                REG_B1B2:   c4_reg  <= cfg_data;
                REG_MCMD:   c5_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic        [31:0] ac4, ac5, ac6;
    assign ac1 = 32'(signed'(c1_reg[15:0]));
    assign ac2 = 32'(signed'(c1_reg[31:16]));
    assign ac3 = 32'(signed'(c2_reg[15:0]));
    assign ac4 = {16'd0, c2_reg[31:16]};
    assign ac5 = {16'd0, c3_reg[15:0]};
    assign ac6 = {16'd0, c3_reg[31:16]};
    assign b1  = 32'(signed'(c4_reg[15:0]));
    assign b2  = 32'(signed'(c4_reg[31:16]));
    assign mc  = 32'(signed'(c5_reg[15:0]));
    assign md  = 32'(signed'(c5_reg[31:16]));

    // output register and global advance
    logic      ov_reg;
    out_word_t od_reg;
    logic      adv;
    assign adv         = !ov_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

    // stage A: x1 product
    logic               a_v_reg;
    logic signed [31:0] a_prod_reg;
    logic        [18:0] a_up_reg;
    logic [31:0] ut;
    assign ut = 32'(signed'(in_ch.data.raw_temperature));

    // stage B: x1, divisor setup
    logic               b_v_reg;
    logic signed [31:0] b_x1_reg, b_num_reg, b_den_reg;
    logic        [18:0] b_up_reg;
    logic [31:0] b_x1_next;
    assign b_x1_next = 32'(a_prod_reg >>> 15);

    // signed divide 1: magnitude in, sign on the side
    logic [31:0] d1_ma, d1_mb;
    logic        d1_neg, d1_zero;
    assign d1_ma   = b_num_reg[31] ? 32'(-b_num_reg) : b_num_reg;
    assign d1_mb   = b_den_reg[31] ? 32'(-b_den_reg) : b_den_reg;
    assign d1_neg  = b_num_reg[31] ^ b_den_reg[31];
    assign d1_zero = (b_den_reg == '0);

    logic                d1_v;
    logic [31:0]         d1_q;
    logic [DivSideW-1:0] d1_side;
    bpc_div_pipe u_div1 (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(b_v_reg),
        .dividend(d1_ma), .divisor(d1_mb),
        .side_in({30'd0, b_x1_reg, d1_neg, d1_zero, b_up_reg, 1'b0}),
        .out_valid(d1_v), .quotient(d1_q), .side_out(d1_side)
    );

    // stage C: b5, b6
    logic               c_v_reg, c_f_reg;
    logic signed [31:0] c_b5_reg, c_b6_reg;
    logic        [18:0] c_up_reg;
    logic [31:0] c_x2;
    assign c_x2 = d1_side[20] ? 32'hFFFF_FFFF : (d1_side[21] ? 32'(-d1_q) : d1_q);

    // stage D: products of b6
    logic               d_v_reg, d_f_reg;
    logic signed [31:0] d_b5_reg, d_b6sqr_reg, d_ac2b6_reg, d_ac3b6_reg;
    logic        [18:0] d_up_reg;
    // stage E
    logic               e_v_reg, e_f_reg;
    logic signed [31:0] e_b5_reg, e_b2p_reg, e_b1p_reg, e_ac2b6_reg, e_ac3b6_reg;
    logic        [18:0] e_up_reg;
    // stage F: b3, x3
    logic               f_v_reg, f_f_reg;
    logic signed [31:0] f_b5_reg, f_b3_reg, f_x3_reg;
    logic        [18:0] f_up_reg;
    // stage G: b4, b7 diff
    logic               g_v_reg, g_f_reg;
    logic signed [31:0] g_b5_reg, g_diff_reg;
    logic        [31:0] g_b4_reg;
    // stage H: b7
    logic               h_v_reg, h_f_reg;
    logic signed [31:0] h_b5_reg;
    logic        [31:0] h_b4_reg, h_b7_reg;

    logic [31:0] f_b3_next, f_x3_next, g_b4_next, g_diff_next, h_b7_next;
    logic [31:0] f_t3, f_t1, f_t2;
    assign f_t3 = 32'(e_b2p_reg >>> 11) + 32'(e_ac2b6_reg >>> 11);
    assign f_b3_next = 32'($signed(32'((32'(ac1 * 4) + f_t3) << oss_reg) + 32'd2) >>> 2);
    assign f_t1 = 32'(e_ac3b6_reg >>> 13);
    assign f_t2 = 32'(e_b1p_reg >>> 16);
    assign f_x3_next = 32'($signed(f_t1 + f_t2 + 32'd2) >>> 2);
    assign g_b4_next = 32'(ac4 * 32'(f_x3_reg + 32'd32768)) >> 15;
    assign g_diff_next = 32'({13'd0, f_up_reg} - f_b3_reg);
    assign h_b7_next = 32'(g_diff_reg * (32'd50000 >> oss_reg));

    logic hi7;
    assign hi7 = h_b7_reg[31];
    logic h_b4_zero;
    assign h_b4_zero = (h_b4_reg == '0);
    logic                d2_v;
    logic [31:0]         d2_q;
    logic [DivSideW-1:0] d2_side;
    bpc_div_pipe u_div2 (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(h_v_reg),
        .dividend(hi7 ? h_b7_reg : {h_b7_reg[30:0], 1'b0}), .divisor(h_b4_reg),
        .side_in({h_b5_reg, 30'd0, h_b4_zero, hi7, h_f_reg | h_b4_zero, 19'd0}),
        .out_valid(d2_v), .quotient(d2_q), .side_out(d2_side)
    );

    // stage I: p
    logic        i_v_reg, i_f_reg;
    logic signed [31:0] i_b5_reg, i_p_reg;
    logic [31:0] i_p_next, i_q;
    assign i_q = (d2_side[21]) ? 32'hFFFF_FFFF : d2_q;
    assign i_p_next = d2_side[20] ? {i_q[30:0], 1'b0} : i_q;
    // stage J: products of p
    logic        j_v_reg, j_f_reg;
    logic signed [31:0] j_b5_reg, j_p_reg, j_sq_reg, j_x2_reg;
    logic signed [31:0] j_p8;
    assign j_p8 = i_p_reg >>> 8;
    // stage K
    logic        k_v_reg, k_f_reg;
    logic signed [31:0] k_b5_reg, k_p_reg, k_x1_reg, k_x2_reg;
    logic signed [31:0] k_m;
    assign k_m = 32'(j_sq_reg * 32'sd3038);
    logic signed [31:0] l_sum, l_q;
    assign l_sum = 32'(k_x1_reg + k_x2_reg + 32'sd3791);
    assign l_q   = 32'((l_sum + (l_sum[31] ? 32'sd15 : 32'sd0)) >>> 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0; b_v_reg <= 1'b0; c_v_reg <= 1'b0; d_v_reg <= 1'b0;
            e_v_reg <= 1'b0; f_v_reg <= 1'b0; g_v_reg <= 1'b0; h_v_reg <= 1'b0;
            i_v_reg <= 1'b0; j_v_reg <= 1'b0; k_v_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= in_ch.valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= d1_v;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
            i_v_reg <= d2_v;
            j_v_reg <= i_v_reg;
            k_v_reg <= j_v_reg;
            ov_reg  <= k_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_prod_reg <= 32'($signed(ut - ac6) * $signed(ac5));
            a_up_reg   <= in_ch.data.raw_pressure;
            b_x1_reg   <= b_x1_next;
            b_num_reg  <= 32'(mc * 2048);
            b_den_reg  <= 32'(b_x1_next + md);
            b_up_reg   <= a_up_reg;
            c_b5_reg   <= 32'(d1_side[53:22] + c_x2);
            c_b6_reg   <= 32'(d1_side[53:22] + c_x2 - 32'd4000);
            c_f_reg    <= d1_side[20];
            c_up_reg   <= d1_side[19:1];
            d_b5_reg    <= c_b5_reg;
            d_b6sqr_reg <= 32'(32'(c_b6_reg * c_b6_reg) >>> 12);
            d_ac2b6_reg <= 32'(ac2 * c_b6_reg);
            d_ac3b6_reg <= 32'(ac3 * c_b6_reg);
            d_f_reg     <= c_f_reg;
            d_up_reg    <= c_up_reg;
            e_b5_reg    <= d_b5_reg;
            e_b2p_reg   <= 32'(b2 * d_b6sqr_reg);
            e_b1p_reg   <= 32'(b1 * d_b6sqr_reg);
            e_ac2b6_reg <= d_ac2b6_reg;
            e_ac3b6_reg <= d_ac3b6_reg;
            e_f_reg     <= d_f_reg;
            e_up_reg    <= d_up_reg;
            f_b5_reg <= e_b5_reg;
            f_b3_reg <= f_b3_next;
            f_x3_reg <= f_x3_next;
            f_f_reg  <= e_f_reg;
            f_up_reg <= e_up_reg;
            g_b5_reg   <= f_b5_reg;
            g_b4_reg   <= g_b4_next;
            g_diff_reg <= g_diff_next;
            g_f_reg    <= f_f_reg;
            h_b5_reg <= g_b5_reg;
            h_b4_reg <= g_b4_reg;
            h_b7_reg <= h_b7_next;
            h_f_reg  <= g_f_reg;
            i_b5_reg <= d2_side[83:52];
            i_p_reg  <= i_p_next;
            i_f_reg  <= d2_side[19];
            j_b5_reg <= i_b5_reg;
            j_p_reg  <= i_p_reg;
            j_sq_reg <= 32'(j_p8 * j_p8);
            j_x2_reg <= 32'(32'(-32'sd7357 * i_p_reg) >>> 16);
            j_f_reg  <= i_f_reg;
            k_b5_reg <= j_b5_reg;
            k_p_reg  <= j_p_reg;
            k_x1_reg <= 32'(k_m >>> 16);
            k_x2_reg <= j_x2_reg;
            k_f_reg  <= j_f_reg;
            od_reg.temperature_out <= 32'(32'(32'(k_b5_reg + 32'sd8) >>> 4) * 32'sd10);
            od_reg.pressure_out    <= 32'(k_p_reg + l_q);
            od_reg.divide_fault    <= k_f_reg;
        end
    end
endmodule

>>> hw/rtl/bpc_checker.sv
// Port-level checks for the compensation core, bound to the top level.
// Depends on bpc_pkg.
module bpc_checker
    import bpc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed under stall");
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");
endmodule

bind barometric_pressure_compensation_core bpc_checker u_bpc_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
